/* hw/rtl/dtne_pkg.sv */
// Shared types, constants and register indexes for the drum trigger note event block.
package dtne_pkg;

   // Field widths of the item and result beats
   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 12;
   localparam int TIME_W     = 32;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;

   // Register widths
   localparam int THRESH_W   = 20;
   localparam int GAIN_W     = 8;
   localparam int DIV_W      = 16;
   localparam int HOLD_W     = 16;
   localparam int TABLE_W    = 56;
   localparam int CSR_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;

   // Channel state slots addressable by the channel field
   localparam int SLOTS      = 8;

   // Parameter defaults
   localparam int DEF_NUM_CHANNELS = 8;
   localparam int DEF_SAMPLE_BITS  = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_DIV    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_MS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_TABLE = 3'd6;

   // Register reset values
   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 20'd500;
   localparam logic [GAIN_W-1:0]   GAIN_RST      = 8'd1;
   localparam logic                VEL_EN_RST    = 1'b1;
   localparam logic [DIV_W-1:0]    VEL_DIV_RST   = 16'd32;
   localparam logic [VEL_W-1:0]    MAX_VEL_RST   = 7'd127;
   localparam logic [HOLD_W-1:0]   HOLD_MS_RST   = 16'd50;
   localparam logic [TABLE_W-1:0]  NOTE_TABLE_RST = {
      7'd55, 7'd36, 7'd52, 7'd40, 7'd69, 7'd67, 7'd60, 7'd50
   };

   typedef struct packed {
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]   now_ms;
   } req_payload_type;

   typedef struct packed {
      logic                note_on;
      logic [CHAN_W-1:0]   out_chan;
      logic [NOTE_W-1:0]   note_number;
      logic [VEL_W-1:0]    note_velocity;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic div_init;
      logic div_step;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_on;
      logic is_off;
      logic need_div;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/dtne_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
interface dtne_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/dtne_ctrl.sv */
// Sequencing state machine: capture, scale, decide, divide, emit.
module dtne_ctrl #(
   parameter int SAMPLE_BITS = dtne_pkg::DEF_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dtne_pkg::status_type sts,
   output dtne_pkg::cmd_type    cmd
);

   localparam int SampleW = (SAMPLE_BITS < dtne_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : dtne_pkg::SAMPLE_W;
   localparam int ScaledW = SampleW + dtne_pkg::GAIN_W;
   localparam int CntW    = $clog2(ScaledW);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.is_on && sts.need_div) begin
               cmd.div_init = 1'b1;
               cnt_in       = CntW'(ScaledW - 1);
               state_in     = ST_DIV;
            end else if (sts.is_on || sts.is_off) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* hw/rtl/dtne_dpath.sv */
// Datapath: registers, scaling, channel state, restoring divider, result register.
module dtne_dpath #(
   parameter int NUM_CHANNELS = dtne_pkg::DEF_NUM_CHANNELS,
   parameter int SAMPLE_BITS  = dtne_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dtne_pkg::cmd_type                   cmd,
   output dtne_pkg::status_type                sts,
   input  dtne_pkg::req_payload_type           req_payload,
   input  logic                                csr_we,
   input  logic [dtne_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dtne_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dtne_pkg::rsp_payload_type           rsp_payload
);

   localparam int SampleW = (SAMPLE_BITS < dtne_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : dtne_pkg::SAMPLE_W;
   localparam int ScaledW = SampleW + dtne_pkg::GAIN_W;
   localparam int Depth   = (NUM_CHANNELS < dtne_pkg::SLOTS) ? NUM_CHANNELS
                                                             : dtne_pkg::SLOTS;
   localparam int IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int ChanCmpW = dtne_pkg::CHAN_W + 2;
   localparam int RemW    = dtne_pkg::DIV_W + 1;

   // Configuration registers
   logic [dtne_pkg::THRESH_W-1:0] thresh_ff;
   logic [dtne_pkg::GAIN_W-1:0]   gain_ff;
   logic                          vel_en_ff;
   logic [dtne_pkg::DIV_W-1:0]    vel_div_ff;
   logic [dtne_pkg::VEL_W-1:0]    max_vel_ff;
   logic [dtne_pkg::HOLD_W-1:0]   hold_ff;
   logic [dtne_pkg::TABLE_W-1:0]  table_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= dtne_pkg::THRESHOLD_RST;
         gain_ff    <= dtne_pkg::GAIN_RST;
         vel_en_ff  <= dtne_pkg::VEL_EN_RST;
         vel_div_ff <= dtne_pkg::VEL_DIV_RST;
         max_vel_ff <= dtne_pkg::MAX_VEL_RST;
         hold_ff    <= dtne_pkg::HOLD_MS_RST;
         table_ff   <= dtne_pkg::NOTE_TABLE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dtne_pkg::REG_THRESHOLD:  thresh_ff  <= csr_wdata[dtne_pkg::THRESH_W-1:0];
            dtne_pkg::REG_GAIN:       gain_ff    <= csr_wdata[dtne_pkg::GAIN_W-1:0];
            dtne_pkg::REG_VEL_ENABLE: vel_en_ff  <= csr_wdata[0];
            dtne_pkg::REG_VEL_DIV:    vel_div_ff <= csr_wdata[dtne_pkg::DIV_W-1:0];
            dtne_pkg::REG_MAX_VEL:    max_vel_ff <= csr_wdata[dtne_pkg::VEL_W-1:0];
            dtne_pkg::REG_HOLD_MS:    hold_ff    <= csr_wdata[dtne_pkg::HOLD_W-1:0];
            dtne_pkg::REG_NOTE_TABLE: table_ff   <= csr_wdata[dtne_pkg::TABLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured item
   logic [dtne_pkg::CHAN_W-1:0] chan_ff;
   logic                        chan_ok_ff;
   logic [SampleW-1:0]          sample_ff;
   logic [dtne_pkg::TIME_W-1:0] now_ff;
   logic [ScaledW-1:0]          scaled_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chan_ff    <= req_payload.chan;
         chan_ok_ff <= ({2'b00, req_payload.chan} < ChanCmpW'(NUM_CHANNELS));
         sample_ff  <= req_payload.sample[SampleW-1:0];
         now_ff     <= req_payload.now_ms;
      end
      if (cmd.load) begin
         scaled_ff <= sample_ff * gain_ff;
      end
   end

   // Per-channel state
   logic [Depth-1:0]            active_ff;
   logic [dtne_pkg::TIME_W-1:0] start_ff [Depth];
   logic [IdxW-1:0]             idx;
   logic                        hit;
   logic [dtne_pkg::TIME_W-1:0] elapsed;
   logic                        is_on;
   logic                        is_off;
   logic                        need_div;

   assign idx      = chan_ff[IdxW-1:0];
   assign hit      = (dtne_pkg::THRESH_W'(scaled_ff) > thresh_ff);
   assign elapsed  = now_ff - start_ff[idx];
   assign is_on    = chan_ok_ff && hit && !active_ff[idx];
   assign is_off   = chan_ok_ff && !hit && active_ff[idx] &&
                     (elapsed > dtne_pkg::TIME_W'(hold_ff));
   assign need_div = vel_en_ff && (vel_div_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < Depth; i++) begin
            start_ff[i] <= '0;
         end
      end else if (cmd.emit) begin
         active_ff[idx] <= is_on;
         start_ff[idx]  <= now_ff;
      end
   end

   // Restoring divider, one quotient bit a cycle
   logic [RemW-1:0]    rem_ff;
   logic [ScaledW-1:0] quo_ff;
   logic [RemW-1:0]    rem_sh;
   logic [RemW-1:0]    rem_diff;
   logic               q_bit;

   assign rem_sh   = {rem_ff[RemW-2:0], quo_ff[ScaledW-1]};
   assign rem_diff = rem_sh - {1'b0, vel_div_ff};
   assign q_bit    = (rem_sh >= {1'b0, vel_div_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= scaled_ff;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_diff : rem_sh;
         quo_ff <= {quo_ff[ScaledW-2:0], q_bit};
      end
   end

   // Velocity selection
   logic [dtne_pkg::VEL_W-1:0] vel_div_clamped;
   logic [dtne_pkg::VEL_W-1:0] vel;
   logic [dtne_pkg::NOTE_W-1:0] note_num;

   assign vel_div_clamped = (quo_ff > ScaledW'(max_vel_ff)) ? max_vel_ff
                                                            : quo_ff[dtne_pkg::VEL_W-1:0];
   assign vel      = !is_on ? '0 : (need_div ? vel_div_clamped : max_vel_ff);
   assign note_num = table_ff[6'(chan_ff) * 6'd7 +: dtne_pkg::NOTE_W];

   // Result register
   logic                      rsp_valid_ff;
   dtne_pkg::rsp_payload_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.note_on       <= is_on;
         rsp_ff.out_chan      <= chan_ff;
         rsp_ff.note_number   <= note_num;
         rsp_ff.note_velocity <= vel;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   assign sts.is_on    = is_on;
   assign sts.is_off   = is_off;
   assign sts.need_div = need_div;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

/* hw/rtl/drum_trigger_to_note_events_core.sv */
// Top level of the drum trigger to note event block.
// A scaled-velocity note-on is accepted, scaled, decided, divided into a SampleW+8 bit quotient
//   (20 bits at 12-bit samples) and emitted into the result register. One beat at a time: the
//   next beat is taken once the last is back in idle. Note-off and fixed-velocity note-on skip
//   the divider, no-event beats end after decide; a waiting event holds the block in emit.
// Synchronous reset clears all channels to idle, start times to zero, registers to defaults.
module drum_trigger_to_note_events_core #(
   parameter int NUM_CHANNELS = dtne_pkg::DEF_NUM_CHANNELS,
   parameter int SAMPLE_BITS  = dtne_pkg::DEF_SAMPLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   dtne_stream_if.sink                     req_chn,
   dtne_stream_if.source                   rsp_chn,
   input  logic                            csr_we,
   input  logic [dtne_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtne_pkg::CSR_DATA_W-1:0] csr_wdata
);

   dtne_pkg::cmd_type         cmd;
   dtne_pkg::status_type      sts;
   dtne_pkg::req_payload_type req_payload;
   dtne_pkg::rsp_payload_type rsp_payload;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_payload     = req_chn.payload;
   assign req_chn.ready   = req_ready;
   assign rsp_chn.valid   = rsp_valid;
   assign rsp_chn.payload = rsp_payload;

   // Controller: sequences each beat and counts divider steps
   dtne_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chn.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: registers, channel state, divider and result register
   dtne_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chn.ready),
      .rsp_payload (rsp_payload)
   );

   // An accepted beat keeps the block busy the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chn.valid && req_ready |=> !req_ready)
      else $error("block ready right after accepting a beat");

   // Note-off events always carry zero velocity
   a_off_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.note_on |-> rsp_payload.note_velocity == '0)
      else $error("note-off with non-zero velocity");

   // Events are only produced from the emit step, never while idle
   a_emit_not_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !req_ready && (sts.is_on || sts.is_off))
      else $error("event emitted without a pending decision");

   // A fresh event only appears after the block was busy
   a_rise_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("event appeared without a busy cycle");

endmodule

/* verif/drum_trigger_to_note_events_core_tb.sv */
// Self-checking testbench for drum_trigger_to_note_events_core: scoreboarded note events.
`timescale 1ns / 100ps

module drum_trigger_to_note_events_core_tb;
   import dtne_pkg::*;

   // Which side is made to idle: receiver stalls, sender gaps, or neither
   typedef enum logic [1:0] {RX_STALLS, TX_GAPS, NO_IDLE} idle_mode_type;

   // Shadow copy of the register file
   typedef struct {
      logic [THRESH_W-1:0] threshold;
      logic [GAIN_W-1:0]   gain;
      logic                vel_en;
      logic [DIV_W-1:0]    vel_div;
      logic [VEL_W-1:0]    max_vel;
      logic [HOLD_W-1:0]   hold;
      logic [TABLE_W-1:0]  note_table;
   } drum_settings_type;

   // Tracks per-channel note state, predicts the event for each trigger beat
   // and checks the events coming back in order.
   class note_tracker;
      drum_settings_type cfg;
      logic              active [SLOTS];
      logic [TIME_W-1:0] started [SLOTS];
      rsp_payload_type   expected_events [$];
      int unsigned       faults;

      function new();
         cfg.threshold  = THRESHOLD_RST;
         cfg.gain       = GAIN_RST;
         cfg.vel_en     = VEL_EN_RST;
         cfg.vel_div    = VEL_DIV_RST;
         cfg.max_vel    = MAX_VEL_RST;
         cfg.hold       = HOLD_MS_RST;
         cfg.note_table = NOTE_TABLE_RST;
         for (int i = 0; i < SLOTS; i++) begin
            active[i]  = 1'b0;
            started[i] = '0;
         end
         faults = 0;
      endfunction

      function void take_trigger(req_payload_type t);
         logic [THRESH_W-1:0] scaled;
         logic [THRESH_W-1:0] quot;
         logic [TIME_W-1:0]   elapsed;
         rsp_payload_type     ev;
         scaled = t.sample * cfg.gain;
         ev.out_chan      = t.chan;
         ev.note_number   = cfg.note_table[NOTE_W*t.chan +: NOTE_W];
         ev.note_velocity = '0;
         if (scaled > cfg.threshold) begin
            if (!active[t.chan]) begin
               // velocity from reading, saturating on a zero divisor
               if (cfg.vel_en && cfg.vel_div != 0) begin
                  quot = scaled / cfg.vel_div;
                  ev.note_velocity = (quot > cfg.max_vel) ? cfg.max_vel : quot[VEL_W-1:0];
               end else begin
                  ev.note_velocity = cfg.max_vel;
               end
               ev.note_on      = 1'b1;
               active[t.chan]  = 1'b1;
               started[t.chan] = t.now_ms;
               expected_events.push_back(ev);
            end
         end else if (active[t.chan]) begin
            elapsed = t.now_ms - started[t.chan];
            if (elapsed > cfg.hold) begin
               ev.note_on      = 1'b0;
               active[t.chan]  = 1'b0;
               started[t.chan] = t.now_ms;
               expected_events.push_back(ev);
            end
         end
      endfunction

      function void check_event(rsp_payload_type got);
         rsp_payload_type exp;
         if (expected_events.size() == 0) begin
            $error("unexpected event beat: note_on %0d chan %0d note %0d vel %0d",
                   got.note_on, got.out_chan, got.note_number, got.note_velocity);
            faults++;
            return;
         end
         exp = expected_events.pop_front();
         if (got.note_on !== exp.note_on) begin
            $error("note_on expected %0d got %0d", exp.note_on, got.note_on);
            faults++;
         end
         if (got.out_chan !== exp.out_chan) begin
            $error("out_chan expected %0d got %0d", exp.out_chan, got.out_chan);
            faults++;
         end
         if (got.note_number !== exp.note_number) begin
            $error("note_number expected %0d got %0d", exp.note_number, got.note_number);
            faults++;
         end
         if (got.note_velocity !== exp.note_velocity) begin
            $error("note_velocity expected %0d got %0d", exp.note_velocity, got.note_velocity);
            faults++;
         end
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dtne_stream_if #(.payload_type(req_payload_type)) req_if ();
   dtne_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   note_tracker   tracker = new();
   idle_mode_type idle_mode = RX_STALLS;
   // millisecond clock for hits, advanced by each generated beat; starts just short of the wrap
   logic [TIME_W-1:0] wall_ms = 32'hFFFF_F800;

   drum_trigger_to_note_events_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chn   (req_if),
      .rsp_chn   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready stalls follow the idle mode
   always @(posedge clock) begin
      case (idle_mode)
         RX_STALLS: begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 81);
         end
         TX_GAPS: begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 16);
         end
         default: begin
            rsp_if.ready <= 1'b1;
         end
      endcase
   end

   // Every event beat taken is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_event(rsp_if.payload);
      end
   end

   // One register write per cycle; the caller drops csr_we afterwards
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // Writes the whole register file; only called with the block idle
   task automatic apply_settings(input logic [THRESH_W-1:0] thr, input logic [GAIN_W-1:0] gn,
                                 input logic en, input logic [DIV_W-1:0] dv,
                                 input logic [VEL_W-1:0] mx, input logic [HOLD_W-1:0] hd,
                                 input logic [TABLE_W-1:0] tbl);
      write_reg(REG_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(REG_GAIN, CSR_DATA_W'(gn));
      write_reg(REG_VEL_ENABLE, CSR_DATA_W'(en));
      write_reg(REG_VEL_DIV, CSR_DATA_W'(dv));
      write_reg(REG_MAX_VEL, CSR_DATA_W'(mx));
      write_reg(REG_HOLD_MS, CSR_DATA_W'(hd));
      write_reg(REG_NOTE_TABLE, CSR_DATA_W'(tbl));
      csr_we <= 1'b0;
      tracker.cfg.threshold  = thr;
      tracker.cfg.gain       = gn;
      tracker.cfg.vel_en     = en;
      tracker.cfg.vel_div    = dv;
      tracker.cfg.max_vel    = mx;
      tracker.cfg.hold       = hd;
      tracker.cfg.note_table = tbl;
      @(posedge clock);
   endtask

   // Sends one trigger beat, with a random lead-in gap, and notes it once taken.
   // valid is left high so back-to-back beats leave no gap on valid.
   task automatic send_trigger(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                               input logic [TIME_W-1:0] at_ms);
      int unsigned     pct;
      int unsigned     gap;
      req_payload_type t;
      pct = (idle_mode == RX_STALLS) ? 16 : (idle_mode == TX_GAPS) ? 81 : 0;
      gap = 0;
      while ($urandom_range(0, 99) < pct) gap++;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      t.chan   = ch;
      t.sample = smp;
      t.now_ms = at_ms;
      req_if.valid   <= 1'b1;
      req_if.payload <= t;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_trigger(t);
   endtask

   // Drains outstanding events, then allows for a silent beat still in flight
   task automatic settle();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Mostly well-formed hit / release traffic aimed at the threshold and hold
   // boundaries, plus some fully random noise beats.
   function automatic req_payload_type make_trigger();
      req_payload_type t;
      int unsigned     knee;
      int unsigned     pick;
      t.chan = CHAN_W'($urandom_range(0, SLOTS - 1));
      pick   = $urandom_range(0, 99);
      // largest sample that stays at or below the threshold
      knee = (tracker.cfg.gain == 0) ? 4095 : tracker.cfg.threshold / tracker.cfg.gain;
      if (knee > 4095) knee = 4095;
      wall_ms += $urandom_range(0, 40);
      if (pick < 15) begin
         t.sample = SAMPLE_W'($urandom);
         t.now_ms = $urandom;
      end else if (tracker.active[t.chan] && pick < 85) begin
         // quiet beat on a sounding note: early, or right round the hold edge
         t.sample = (pick % 2 == 0) ? SAMPLE_W'(knee) : SAMPLE_W'($urandom_range(0, knee));
         if (pick < 25) begin
            t.now_ms = tracker.started[t.chan] + $urandom_range(0, tracker.cfg.hold);
         end else begin
            t.now_ms = tracker.started[t.chan] + tracker.cfg.hold + $urandom_range(0, 3) - 1;
         end
      end else begin
         // hit; lands on an active channel now and then and is dropped there
         if (knee >= 4095) begin
            t.sample = SAMPLE_W'($urandom);
         end else if (pick % 3 == 0) begin
            t.sample = SAMPLE_W'(knee + 1);
         end else begin
            t.sample = SAMPLE_W'($urandom_range(knee + 1, 4095));
         end
         t.now_ms = wall_ms;
      end
      return t;
   endfunction

   initial begin
      int unsigned         gn;
      int unsigned         thr;
      int unsigned         dv;
      logic [HOLD_W-1:0]   hd;
      logic [TABLE_W-1:0]  tbl;
      req_payload_type     t;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: hit, hit on sounding note, hold edge, release,
      // release across the time wrap, quiet beat on idle channel
      send_trigger(3'd0, 12'd4095, 32'd0);
      send_trigger(3'd0, 12'd4095, 32'd10);
      send_trigger(3'd0, 12'd0, 32'd50);
      send_trigger(3'd0, 12'd500, 32'd51);
      send_trigger(3'd1, 12'd501, 32'd100);
      send_trigger(3'd1, 12'd0, 32'd0);
      send_trigger(3'd2, 12'd0, 32'd5);
      send_trigger(3'd7, 12'd4095, 32'hFFFF_FFF0);
      send_trigger(3'd7, 12'd0, 32'h0000_0030);
      send_trigger(3'd3, 12'hAAA, 32'h5555_5555);
      send_trigger(3'd3, 12'h555, 32'h5555_5556);
      send_trigger(3'd3, 12'd0, 32'hAAAA_AAAA);
      settle();

      // Zero threshold, full gain, zero divisor saturates, zero hold
      apply_settings(20'd0, 8'd255, 1'b1, 16'd0, 7'd99, 16'd0, {TABLE_W{1'b1}});
      send_trigger(3'd4, 12'd1, 32'd1000);
      send_trigger(3'd4, 12'd0, 32'd1000);
      send_trigger(3'd4, 12'd0, 32'd1001);
      send_trigger(3'd5, 12'd4095, 32'd7);
      settle();

      // Zero gain under the top threshold: only releases, longest hold
      apply_settings(20'hF_FFFF, 8'd0, 1'b0, 16'hFFFF, 7'd0, 16'hFFFF, '0);
      send_trigger(3'd5, 12'd4095, 32'd65542);
      send_trigger(3'd5, 12'd4095, 32'd65543);
      send_trigger(3'd6, 12'd4095, 32'd0);
      settle();

      // Fixed velocity
      apply_settings(20'd1, 8'd255, 1'b0, 16'hFFFF, 7'd77, 16'd0, NOTE_TABLE_RST);
      send_trigger(3'd6, 12'd4095, 32'd3);
      send_trigger(3'd6, 12'd0, 32'd3);
      settle();

      // Random phases: a fresh register set each, idling pattern by thirds
      for (int phase = 0; phase < 11; phase++) begin
         idle_mode = (phase < 4) ? RX_STALLS : (phase < 8) ? TX_GAPS : NO_IDLE;
         gn = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 255);
         if (gn == 0) begin
            thr = $urandom_range(0, 20'hF_FFFF);
         end else begin
            thr = $urandom_range(50, 4000) * gn + $urandom_range(0, gn - 1);
         end
         if (thr > 20'hF_FFFF) thr = 20'hF_FFFF;
         // divisor chosen so velocities spread across and past the clamp
         case ($urandom_range(0, 9))
            0: dv = 0;
            1: dv = $urandom_range(1, 16'hFFFF);
            default: dv = thr / $urandom_range(20, 200) + 1;
         endcase
         if (dv > 16'hFFFF) dv = 16'hFFFF;
         hd  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : HOLD_W'($urandom_range(0, 400));
         tbl = TABLE_W'({$urandom, $urandom});
         apply_settings(THRESH_W'(thr), GAIN_W'(gn), ($urandom_range(0, 3) != 0), DIV_W'(dv),
                        VEL_W'($urandom_range(0, 127)), hd, tbl);
         for (int n = 0; n < 150; n++) begin
            t = make_trigger();
            send_trigger(t.chan, t.sample, t.now_ms);
         end
         settle();
      end

      if (tracker.faults == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
